@@ hw/rtl/gelu_pkg.sv @@
// Shared constants, types and the exp2 table for the GELU pipeline.
`timescale 1ns / 1ps
package gelu_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 12;

	localparam int NUM_STAGES = 12;
	localparam int STG_ARG    = 0;
	localparam int STG_EXP    = 6;
	localparam int STG_DIV    = 7;
	localparam int DIV_STAGES = 4;
	localparam int STG_MIX    = 11;

	localparam int Q_FRAC = 16;
	localparam int A_W    = 20;
	localparam int A2_W   = 23;
	localparam int A3_W   = 26;
	localparam int P_W    = 21;
	localparam int U_W    = 22;
	localparam int V_W    = 23;
	localparam int E_W    = 17;
	localparam int T_W    = 16;
	localparam int W_W    = 17;

	localparam logic [A_W-1:0] A_CLAMP   = 20'h80000;
	localparam logic [11:0]    C_CUBIC   = 12'd2930;
	localparam logic [16:0]    C_SQRT8PI = 17'd104580;
	localparam logic [16:0]    C_LOG2E   = 17'd94548;
	localparam logic [W_W-1:0] Q_ONE     = 17'd65536;
	localparam logic [T_W-1:0] T_MAX     = 16'h8000;

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic [NUM_STAGES-1:0] vld;
	} pipe_ctl_t;

	function automatic logic [E_W-1:0] exp2_tab(input logic [4:0] k);
		logic [E_W-1:0] val;
		case (k)
			5'd0:    val = 17'd65536;
			5'd1:    val = 17'd62757;
			5'd2:    val = 17'd60097;
			5'd3:    val = 17'd57549;
			5'd4:    val = 17'd55109;
			5'd5:    val = 17'd52773;
			5'd6:    val = 17'd50535;
			5'd7:    val = 17'd48393;
			5'd8:    val = 17'd46341;
			5'd9:    val = 17'd44376;
			5'd10:   val = 17'd42495;
			5'd11:   val = 17'd40693;
			5'd12:   val = 17'd38968;
			5'd13:   val = 17'd37316;
			5'd14:   val = 17'd35734;
			5'd15:   val = 17'd34219;
			5'd16:   val = 17'd32768;
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

@@ hw/rtl/gelu_if.sv @@
// Valid/ready channel interfaces for GELU samples and results.
`timescale 1ns / 1ps
interface gelu_in_if #(
	parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] x_in;

	modport source (output valid, output x_in, input ready);
	modport sink (input valid, input x_in, output ready);
endinterface

interface gelu_out_if #(
	parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] gelu_out;

	modport source (output valid, output gelu_out, input ready);
	modport sink (input valid, input gelu_out, output ready);
endinterface

@@ hw/rtl/gelu_ctl.sv @@
// Pipeline valid bits and per-stage advance enables.
`timescale 1ns / 1ps
module gelu_ctl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_ready,
	output gelu_pkg::pipe_ctl_t ctl
);
	import gelu_pkg::*;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] en;

	// advance a stage when the output is ready or any stage from it onwards holds a bubble
	for (genvar j = 0; j < NUM_STAGES; j++) begin : g_en
		assign en[j] = out_ready | ~(&vld_q[NUM_STAGES-1:j]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int j = 1; j < NUM_STAGES; j++) begin
				if (en[j]) begin
					vld_q[j] <= vld_q[j-1];
				end
			end
		end
	end

	assign ctl.en  = en;
	assign ctl.vld = vld_q;

endmodule

@@ hw/rtl/gelu_arg.sv @@
// Magnitude, Q16 conversion and the cubic exponent argument (stages 1 to 6).
`timescale 1ns / 1ps
module gelu_arg #(
	parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = gelu_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  gelu_pkg::pipe_ctl_t          ctl,
	input  logic signed [DATA_WIDTH-1:0] x_in,
	output logic [DATA_WIDTH-1:0]        m_s1,
	output logic                         neg_s1,
	output logic [gelu_pkg::V_W-1:0]     v_s6
);
	import gelu_pkg::*;

	localparam int WIDE_W = DATA_WIDTH + Q_FRAC;
	localparam int SH_L   = (FRAC_BITS < Q_FRAC) ? (Q_FRAC - FRAC_BITS) : 0;
	localparam int SH_R   = (FRAC_BITS >= Q_FRAC) ? (FRAC_BITS - Q_FRAC) : 0;

	logic [DATA_WIDTH-1:0]   xu;
	logic                    x_neg;
	logic [DATA_WIDTH-1:0]   mag;
	logic [WIDE_W-1:0]       wide;
	logic [A_W-1:0]          a_cl;
	logic [2*A_W-1:0]        sq;
	logic [A2_W+A_W-1:0]     cu;
	logic [A3_W+12-1:0]      ct;
	logic [P_W+17-1:0]       up;
	logic [U_W+17-1:0]       vp;

	logic [A_W-1:0]  a_s1, a_s2, a_s3;
	logic [A2_W-1:0] a2_s2;
	logic [A3_W-1:0] a3_s3;
	logic [P_W-1:0]  p_s4;
	logic [U_W-1:0]  u_s5;

	always_comb begin
		xu    = x_in;
		x_neg = xu[DATA_WIDTH-1];
		mag   = x_neg ? (~xu + 1'b1) : xu;
		wide  = (WIDE_W'(mag) << SH_L) >> SH_R;
		a_cl  = (wide > WIDE_W'(A_CLAMP)) ? A_CLAMP : wide[A_W-1:0];
		sq    = a_s1 * a_s1;
		cu    = a2_s2 * a_s2;
		ct    = a3_s3 * C_CUBIC;
		up    = p_s4 * C_SQRT8PI;
		vp    = u_s5 * C_LOG2E;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[STG_ARG]) begin
			m_s1   <= mag;
			neg_s1 <= x_neg;
			a_s1   <= a_cl;
		end
		if (ctl.en[STG_ARG+1]) begin
			a_s2  <= a_s1;
			a2_s2 <= sq[Q_FRAC +: A2_W];
		end
		if (ctl.en[STG_ARG+2]) begin
			a_s3  <= a_s2;
			a3_s3 <= cu[Q_FRAC +: A3_W];
		end
		if (ctl.en[STG_ARG+3]) begin
			p_s4 <= P_W'(a_s3) + ct[Q_FRAC +: P_W];
		end
		if (ctl.en[STG_ARG+4]) begin
			u_s5 <= up[Q_FRAC +: U_W];
		end
		if (ctl.en[STG_ARG+5]) begin
			v_s6 <= vp[Q_FRAC +: V_W];
		end
	end

endmodule

@@ hw/rtl/gelu_exp.sv @@
// Table-based exp(-|u|) with linear interpolation and octave shift (stage 7).
`timescale 1ns / 1ps
module gelu_exp (
	input  logic                     clk,
	input  gelu_pkg::pipe_ctl_t      ctl,
	input  logic [gelu_pkg::V_W-1:0] v_s6,
	output logic [gelu_pkg::E_W-1:0] e_s7
);
	import gelu_pkg::*;

	logic [6:0]     n;
	logic [3:0]     k;
	logic [11:0]    r;
	logic [E_W-1:0] t0, t1, diff;
	logic [23:0]    slope;
	logic [E_W-1:0] e0;
	logic [E_W-1:0] e;

	always_comb begin
		n     = v_s6[V_W-1:16];
		k     = v_s6[15:12];
		r     = v_s6[11:0];
		t0    = exp2_tab(5'(k));
		t1    = exp2_tab(5'(k) + 5'd1);
		diff  = t0 - t1;
		slope = diff[11:0] * r;
		e0    = t0 - E_W'(slope[23:12]);
		e     = (n > 7'd16) ? '0 : (e0 >> n[4:0]);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[STG_EXP]) begin
			e_s7 <= e;
		end
	end

endmodule

@@ hw/rtl/gelu_div.sv @@
// Pipelined restoring divider for e / (1 + e), four quotient bits a stage.
`timescale 1ns / 1ps
module gelu_div (
	input  logic                     clk,
	input  gelu_pkg::pipe_ctl_t      ctl,
	input  logic [gelu_pkg::E_W-1:0] e_s7,
	output logic [gelu_pkg::T_W-1:0] t_s11
);
	import gelu_pkg::*;

	localparam int R_W = E_W + 1;

	typedef struct packed {
		logic [R_W-1:0] rem;
		logic [R_W-1:0] den;
		logic [T_W-1:0] q;
	} div_state_t;

	function automatic div_state_t div_step4(input div_state_t s);
		div_state_t   o;
		logic [R_W:0] rem2;
		o = s;
		for (int i = 0; i < 4; i++) begin
			rem2 = {o.rem, 1'b0};
			if (rem2 >= {1'b0, o.den}) begin
				rem2  = rem2 - {1'b0, o.den};
				o.q   = {o.q[T_W-2:0], 1'b1};
			end else begin
				o.q   = {o.q[T_W-2:0], 1'b0};
			end
			o.rem = rem2[R_W-1:0];
		end
		return o;
	endfunction

	div_state_t div_in;
	div_state_t div_s8, div_s9, div_s10, div_s11;

	always_comb begin
		div_in.rem = R_W'(e_s7);
		div_in.den = R_W'(Q_ONE) + R_W'(e_s7);
		div_in.q   = '0;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[STG_DIV]) begin
			div_s8 <= div_step4(div_in);
		end
		if (ctl.en[STG_DIV+1]) begin
			div_s9 <= div_step4(div_s8);
		end
		if (ctl.en[STG_DIV+2]) begin
			div_s10 <= div_step4(div_s9);
		end
		if (ctl.en[STG_DIV+3]) begin
			div_s11 <= div_step4(div_s10);
		end
	end

	assign t_s11 = div_s11.q;

endmodule

@@ hw/rtl/gelu_mix.sv @@
// Final weighting of |x|, rounding, saturation and sign restore (stage 12).
`timescale 1ns / 1ps
module gelu_mix #(
	parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  gelu_pkg::pipe_ctl_t      ctl,
	input  logic [DATA_WIDTH-1:0]    m_s11,
	input  logic                     neg_s11,
	input  logic [gelu_pkg::T_W-1:0] t_s11,
	output logic [DATA_WIDTH-1:0]    gelu_out_s12
);
	import gelu_pkg::*;

	localparam int PR_W = DATA_WIDTH + W_W;
	localparam logic [DATA_WIDTH:0] MAXPOS = {2'b00, {(DATA_WIDTH-1){1'b1}}};

	logic [W_W-1:0]        w;
	logic [PR_W-1:0]       prod;
	logic [DATA_WIDTH:0]   y;
	logic [DATA_WIDTH:0]   lim;
	logic [DATA_WIDTH:0]   ysat;
	logic [DATA_WIDTH-1:0] res;
	logic [DATA_WIDTH-1:0] res_signed;

	always_comb begin
		w          = neg_s11 ? W_W'(t_s11) : (Q_ONE - W_W'(t_s11));
		prod       = PR_W'(m_s11) * PR_W'(w) + PR_W'(32'h8000);
		y          = prod[Q_FRAC +: DATA_WIDTH+1];
		lim        = neg_s11 ? (MAXPOS + 1'b1) : MAXPOS;
		ysat       = (y > lim) ? lim : y;
		res        = ysat[DATA_WIDTH-1:0];
		res_signed = neg_s11 ? (~res + 1'b1) : res;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[STG_MIX]) begin
			gelu_out_s12 <= res_signed;
		end
	end

endmodule

@@ hw/rtl/gelu_activation_unit.sv @@
// GELU (tanh form) activation pipeline, top level.
//
//   channel  role  payload                 handshake
//   sample   sink  x_in     (signed Q4.12)  valid/ready
//   result   src   gelu_out (signed Q4.12)  valid/ready
//
// One sample per cycle sustained while the result port is ready; twelve register stages.
// The stages are magnitude and Q16 conversion, five multiplier stages, the table stage,
// four divider stages and the output stage.
// Reset clears only the stage valid bits; the datapath registers are not reset.
// A stall at the result port holds the full pipeline; bubbles still close up behind it.
`timescale 1ns / 1ps
module gelu_activation_unit #(
	parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = gelu_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	gelu_in_if.sink   sample,
	gelu_out_if.source result
);
	import gelu_pkg::*;

	pipe_ctl_t             ctl;
	logic [DATA_WIDTH-1:0] m_s1;
	logic                  neg_s1;
	logic [V_W-1:0]        v_s6;
	logic [E_W-1:0]        e_s7;
	logic [T_W-1:0]        t_s11;
	logic [DATA_WIDTH-1:0] gelu_out_s12;
	logic [DATA_WIDTH-1:0] m_s   [2:NUM_STAGES-1];
	logic                  neg_s [2:NUM_STAGES-1];

	gelu_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.out_ready (result.ready),
		.ctl       (ctl)
	);

	gelu_arg #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_arg (
		.clk    (clk),
		.ctl    (ctl),
		.x_in   (sample.x_in),
		.m_s1   (m_s1),
		.neg_s1 (neg_s1),
		.v_s6   (v_s6)
	);

	gelu_exp u_exp (
		.clk  (clk),
		.ctl  (ctl),
		.v_s6 (v_s6),
		.e_s7 (e_s7)
	);

	gelu_div u_div (
		.clk   (clk),
		.ctl   (ctl),
		.e_s7  (e_s7),
		.t_s11 (t_s11)
	);

	// carry magnitude and sign alongside the datapath
	for (genvar i = 2; i < NUM_STAGES; i++) begin : g_side
		if (i == 2) begin : g_first
			always_ff @(posedge clk) begin
				if (ctl.en[i-1]) begin
					m_s[i]   <= m_s1;
					neg_s[i] <= neg_s1;
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (ctl.en[i-1]) begin
					m_s[i]   <= m_s[i-1];
					neg_s[i] <= neg_s[i-1];
				end
			end
		end
	end

	gelu_mix #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_mix (
		.clk          (clk),
		.ctl          (ctl),
		.m_s11        (m_s[NUM_STAGES-1]),
		.neg_s11      (neg_s[NUM_STAGES-1]),
		.t_s11        (t_s11),
		.gelu_out_s12 (gelu_out_s12)
	);

	assign sample.ready    = ctl.en[0];
	assign result.valid    = ctl.vld[NUM_STAGES-1];
	assign result.gelu_out = gelu_out_s12;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (&ctl.vld))
		else $error("input stalled with a bubble in the pipeline");

	a_full_and_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		((&ctl.vld) && !result.ready) |-> !sample.ready)
		else $error("input taken while the full pipeline is blocked");

	a_weight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.vld[STG_MIX-1] |-> (t_s11 <= T_MAX))
		else $error("tail weight above one half");

	a_positive_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.vld[STG_MIX-1] && ctl.en[STG_MIX] && !neg_s[NUM_STAGES-1])
		|=> !result.gelu_out[DATA_WIDTH-1])
		else $error("non-negative sample gave a negative word");

endmodule

@@ tb/gelu_activation_unit_tb.sv @@
// Self-checking testbench for the GELU pipeline: random handshakes, stalls and a bit-exact predictor.
`timescale 1ns / 1ps
module gelu_activation_unit_tb;

	import gelu_pkg::*;

	localparam int DW        = DATA_WIDTH_DEF;
	localparam int FB        = FRAC_BITS_DEF;
	localparam int LATENCY   = NUM_STAGES;
	localparam int MAX_CYCLES = 200000;
	localparam int HOLD_LEN  = 150;

	localparam int UP_SHIFT   = (FB < 16) ? 16 - FB : 0;
	localparam int DOWN_SHIFT = (FB >= 16) ? FB - 16 : 0;

	localparam logic [63:0] ARG_CLAMP   = 64'd524288;
	localparam logic [63:0] CUBIC_Q16   = 64'd2930;
	localparam logic [63:0] SQRT8PI_Q16 = 64'd104580;
	localparam logic [63:0] LOG2E_Q16   = 64'd94548;
	localparam logic [63:0] ONE_Q16     = 64'd65536;
	localparam logic [63:0] HALF_Q16    = 64'd32768;
	localparam logic [63:0] MAX_POS     = (64'd1 << (DW - 1)) - 64'd1;

	localparam logic [16:0] POW2_STEP [17] = '{
		17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
		17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
		17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
	};

	localparam int CORNER_X [24] = '{
		0, 1, -1, 2, -2, 7, -8, 2048, -2048, 4096, -4096, 8192, -8192,
		12288, -12288, 16384, -16384, 24576, -24576, 32767, -32767, -32768,
		21845, -21846
	};

	logic clk = 1'b0;
	logic arst_n;

	gelu_in_if  #(.DATA_WIDTH(DW)) sample_ch ();
	gelu_out_if #(.DATA_WIDTH(DW)) result_ch ();

	gelu_activation_unit #(
		.DATA_WIDTH(DW),
		.FRAC_BITS (FB)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch)
	);

	logic signed [DW-1:0] x_pending_q[$];
	logic signed [DW-1:0] gelu_expected_q[$];

	bit          send_idle;
	bit          recv_idle;
	int unsigned send_wait;
	int unsigned recv_wait;
	int unsigned recv_next;
	int unsigned hold_left;
	int unsigned words_sent;
	int unsigned words_checked;
	int unsigned mismatches;
	int unsigned cycles;
	logic signed [DW-1:0] gelu_want;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic signed [DW-1:0] gelu_fixed(input logic signed [DW-1:0] x);
		logic        neg;
		logic [DW:0] mag;
		logic [63:0] arg;
		logic [63:0] sq;
		logic [63:0] cube;
		logic [63:0] poly;
		logic [63:0] scaled;
		logic [63:0] expo;
		logic [63:0] whole;
		logic [4:0]  seg;
		logic [63:0] rem;
		logic [63:0] decay;
		logic [63:0] tail;
		logic [63:0] y;
		neg = x[DW-1];
		mag = neg ? ({1'b0, ~x} + 1'b1) : {1'b0, x};
		arg = (64'(mag) << UP_SHIFT) >> DOWN_SHIFT;
		if (arg > ARG_CLAMP)
			arg = ARG_CLAMP;
		sq     = (arg * arg) >> 16;
		cube   = (sq * arg) >> 16;
		poly   = arg + ((cube * CUBIC_Q16) >> 16);
		scaled = (poly * SQRT8PI_Q16) >> 16;
		expo   = (scaled * LOG2E_Q16) >> 16;
		whole  = expo >> 16;
		seg    = {1'b0, expo[15:12]};
		rem    = 64'(expo[11:0]);
		decay  = 64'(POW2_STEP[seg])
			- (((64'(POW2_STEP[seg]) - 64'(POW2_STEP[seg + 5'd1])) * rem) >> 12);
		if (whole > 64'd31)
			decay = 64'd0;
		else
			decay = decay >> whole;
		tail = (decay << 16) / (ONE_Q16 + decay);
		if (!neg) begin
			y = (64'(mag) * (ONE_Q16 - tail) + HALF_Q16) >> 16;
			if (y > MAX_POS)
				y = MAX_POS;
			return DW'(y);
		end
		y = (64'(mag) * tail + HALF_Q16) >> 16;
		if (y > MAX_POS + 64'd1)
			y = MAX_POS + 64'd1;
		return DW'(64'd0 - y);
	endfunction

	function automatic int unsigned idle_draw(input bit idle_on);
		if (idle_on && $urandom_range(0, 2) == 0)
			return $urandom_range(0, 7);
		return 0;
	endfunction

	task automatic queue_random(input int count);
		logic signed [DW-1:0] x;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0:       x = $urandom_range(0, 1) ? DW'(MAX_POS) : DW'(MAX_POS + 64'd1);
				1, 2, 3, 4: x = DW'($urandom);
				default: x = DW'($urandom_range(0, 32768) - 16384);
			endcase
			x_pending_q.push_back(x);
		end
	endtask

	task automatic wait_sent();
		do
			@(posedge clk);
		while (x_pending_q.size() != 0 || sample_ch.valid);
	endtask

	// sender: one word per handshake, random gap drawn per word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.x_in  <= '0;
			send_wait       <= 0;
			words_sent      <= 0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				gelu_expected_q.push_back(gelu_fixed(sample_ch.x_in));
				words_sent <= words_sent + 1;
			end
			if (!sample_ch.valid || sample_ch.ready) begin
				if (send_wait != 0) begin
					send_wait       <= send_wait - 1;
					sample_ch.valid <= 1'b0;
				end else if (x_pending_q.size() != 0) begin
					sample_ch.valid <= 1'b1;
					sample_ch.x_in  <= x_pending_q.pop_front();
					send_wait       <= idle_draw(send_idle);
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, twice, while the sender keeps offering
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (sample_ch.valid && sample_ch.ready
				&& (words_sent == 60 || words_sent == 300)) begin
			hold_left <= HOLD_LEN;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver: check each word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			recv_wait       <= 0;
			words_checked   <= 0;
			mismatches      <= 0;
		end else begin
			recv_next = recv_wait;
			if (result_ch.valid && result_ch.ready) begin
				words_checked <= words_checked + 1;
				if (gelu_expected_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result word %0d", $realtime,
							result_ch.gelu_out);
					mismatches <= mismatches + 1;
				end else begin
					gelu_want = gelu_expected_q.pop_front();
					if (result_ch.gelu_out !== gelu_want) begin
						if (mismatches < 10)
							$display("%0t: gelu_out mismatch: expected %0d, got %0d",
								$realtime, gelu_want, result_ch.gelu_out);
						mismatches <= mismatches + 1;
					end
				end
				recv_next = idle_draw(recv_idle);
			end else if (recv_next != 0) begin
				recv_next = recv_next - 1;
			end
			recv_wait       <= recv_next;
			result_ch.ready <= (recv_next == 0) && (hold_left == 0);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == MAX_CYCLES) begin
			$display("Timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		cycles          = 0;
		arst_n          = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.x_in  = '0;
		result_ch.ready = 1'b0;
		send_idle       = 1'b1;
		recv_idle       = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (CORNER_X[i])
			x_pending_q.push_back(DW'(CORNER_X[i]));
		queue_random(150);
		wait_sent();

		send_idle <= 1'b0;
		recv_idle <= 1'b0;
		queue_random(130);
		wait_sent();

		recv_idle <= 1'b1;
		queue_random(60);
		wait_sent();

		send_idle <= 1'b1;
		recv_idle <= 1'b0;
		queue_random(60);
		wait_sent();

		while (gelu_expected_q.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		$display("Sent %0d samples (corner values, full range and the curved region) and checked %0d results,",
			words_sent, words_checked);
		$display("with random gaps on both sides, gap-free stretches and two long result stalls; %0d mismatches.",
			mismatches);
		if (mismatches == 0 && gelu_expected_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
